// ===== sv/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

	// Screen geometry.
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;

	// Address of one cell, linear position (which can reach CELLS), row and column.
	localparam int ADDR_W = $clog2(CELLS);
	localparam int POS_W  = $clog2(CELLS + 1);
	localparam int ROW_W  = $clog2(ROWS + 1);
	localparam int COL_W  = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;

	// Widths of the fields on the ports.
	localparam int CURSOR_W = 11;
	localparam int INDEX_W  = 11;
	localparam int CELL_W   = 16;
	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 8;

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'h0A;
	localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
	localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h02;
	localparam logic [CELL_W-1:0]  RESET_CELL   = {RESET_COLOR, BLANK_CHAR};
	localparam logic [CELL_W-1:0]  SCROLL_CELL  = {{COLOR_W{1'b0}}, BLANK_CHAR};

	localparam logic ACTION_PUT  = 1'b0;
	localparam logic ACTION_READ = 1'b1;

	typedef logic [CELL_W-1:0] cell_t;

endpackage

`default_nettype wire

// ===== sv/text_console_writer.sv =====
// Text console engine with an 80x25 store of 16-bit cells (attribute in the
// high byte, character in the low byte) and a row/column cursor.
// Item channel (item_valid/item_stall): action 0 puts char_code at the cursor
// with the current text color (10 is newline); action 1 reads the cell at
// read_index. Each item yields one transfer on the result channel
// (result_valid/result_stall) carrying the linear cursor position and, for a
// read, the cell. Items are taken one at a time; item_stall is high while one
// is being worked on. A put that scrolls first copies the rows up one row
// through the single store port pair and then blanks the bottom row; the
// store memory moves one cell a cycle.
// After reset a clearing pass writes every cell to blank green with item_stall
// high; color writes are taken meanwhile.
// A stalled result stays put; the next item is accepted while it waits.
// The color register (cfg_valid/cfg_ready) is always ready.

`default_nettype none

module text_console_writer
	import tcw_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [COLOR_W-1:0]   cfg_data,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  wire                  action,
	input  wire  [CHAR_W-1:0]    char_code,
	input  wire  [INDEX_W-1:0]   read_index,
	output logic                 result_valid,
	input  wire                  result_stall,
	output logic [CURSOR_W-1:0]  cursor_pos,
	output logic [CELL_W-1:0]    cell_data
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_PUT   = 3'd2;
	localparam logic [2:0] S_COPY  = 3'd3;
	localparam logic [2:0] S_FILL  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]          state_q;
	logic [POS_W-1:0]    idx_q;
	logic                pend_q;
	logic                after_put_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [COLOR_W-1:0]  color_q;
	logic [CHAR_W-1:0]   char_q;
	logic                is_read_q;
	logic                in_range_q;
	logic                result_valid_q;
	logic [POS_W-1:0]    pos_q;
	cell_t               cell_q;

	cell_t               store [CELLS];
	cell_t               rd_data_q;

	logic                item_acc;
	logic                result_acc;
	logic                result_free;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	cell_t               mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [POS_W-1:0]    cursor_lin;
	logic [POS_W-1:0]    copy_waddr;
	logic                index_ok;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != S_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result_acc   = result_valid_q && !result_stall;
	assign result_free  = !result_valid_q || !result_stall;
	assign cursor_pos   = CURSOR_W'(pos_q);
	assign cell_data    = cell_q;

	assign cursor_lin = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);
	// The copy writes one row above the cell read in the previous cycle.
	assign copy_waddr = idx_q - POS_W'(COLUMNS + 1);
	assign index_ok   = (32'(read_index) < CELLS);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = RESET_CELL;
		mem_re    = 1'b0;
		mem_raddr = read_index[ADDR_W-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[ADDR_W-1:0];
				mem_wdata = RESET_CELL;
			end
			S_IDLE: begin
				mem_re = item_acc && (action == ACTION_READ) && index_ok;
			end
			S_PUT: begin
				mem_we    = (char_q != NEWLINE_CODE);
				mem_waddr = cursor_lin[ADDR_W-1:0];
				mem_wdata = {color_q, char_q};
			end
			S_COPY: begin
				mem_we    = pend_q;
				mem_waddr = copy_waddr[ADDR_W-1:0];
				mem_wdata = rd_data_q;
				mem_re    = (idx_q != POS_W'(CELLS));
				mem_raddr = idx_q[ADDR_W-1:0];
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[ADDR_W-1:0];
				mem_wdata = SCROLL_CELL;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= store[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			color_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			idx_q          <= '0;
			pend_q         <= 1'b0;
			after_put_q    <= 1'b0;
			row_q          <= '0;
			col_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_acc) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == POS_W'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_acc) begin
						if (action == ACTION_READ) begin
							state_q <= S_DONE;
						end else if (row_q == ROW_W'(ROWS)) begin
							// A wrap past the bottom is pending: scroll first.
							row_q       <= ROW_W'(ROWS - 1);
							col_q       <= '0;
							after_put_q <= 1'b1;
							idx_q       <= POS_W'(COLUMNS);
							pend_q      <= 1'b0;
							state_q     <= S_COPY;
						end else begin
							state_q <= S_PUT;
						end
					end
				end
				S_PUT: begin
					if (char_q == NEWLINE_CODE) begin
						col_q <= '0;
						if (row_q == ROW_W'(ROWS - 1)) begin
							after_put_q <= 1'b0;
							idx_q       <= POS_W'(COLUMNS);
							pend_q      <= 1'b0;
							state_q     <= S_COPY;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= S_DONE;
						end
					end else begin
						if (col_q == COL_W'(COLUMNS - 1)) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_COPY: begin
					if (idx_q == POS_W'(CELLS)) begin
						idx_q   <= POS_W'(CELLS - COLUMNS);
						pend_q  <= 1'b0;
						state_q <= S_FILL;
					end else begin
						idx_q  <= idx_q + 1'b1;
						pend_q <= 1'b1;
					end
				end
				S_FILL: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == POS_W'(CELLS - 1)) begin
						state_q <= after_put_q ? S_PUT : S_DONE;
					end
				end
				S_DONE: begin
					if (result_free) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			char_q     <= char_code;
			is_read_q  <= (action == ACTION_READ);
			in_range_q <= index_ok;
		end
		if (state_q == S_DONE && result_free) begin
			pos_q  <= cursor_lin;
			cell_q <= (is_read_q && in_range_q) ? rd_data_q : '0;
		end
	end

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= ROW_W'(ROWS)) && ((row_q != ROW_W'(ROWS)) || (col_q == '0)))
		else $error("cursor row out of range or wrap pending with nonzero column");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(COLUMNS - 1))
		else $error("cursor column out of range");

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> (state_q != S_IDLE))
		else $error("item transfer did not start work");

	a_copy_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COPY && idx_q == POS_W'(CELLS)) |-> pend_q)
		else $error("scroll copy ended without its last write");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (row_q == ROW_W'(ROWS - 1)))
		else $error("scroll running with cursor off the bottom row");

endmodule

`default_nettype wire
